// ===== src/gvx_pkg.sv =====
package gvx_pkg;

    localparam int DEF_MAX_X = 128;
    localparam int DEF_MAX_Y = 128;
    localparam int MAX_Z     = 1024;

    localparam int VEL_W     = 24;
    localparam int SUM_W     = VEL_W + 3;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 11;
    localparam int ZW        = $clog2(MAX_Z + 1);
    localparam int ZPW       = $clog2(MAX_Z);
    localparam int QDEPTH    = 4;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = 2'd2;

    // neighbour enable bits
    localparam int NB_XP = 0;
    localparam int NB_XM = 1;
    localparam int NB_YP = 2;
    localparam int NB_YM = 3;
    localparam int NB_ZM = 4;
    localparam int NB_ZP = 5;
    localparam int NB_N  = 6;

    typedef struct packed {
        logic                    mark;
        logic signed [VEL_W-1:0] vel;
    } entry_t;

    typedef struct packed {
        entry_t          entry;
        logic            emit;
        logic [NB_N-1:0] nb_en;
        logic            last;
    } cmd_t;

endpackage

// ===== src/grid_velocity_extrapolation_pass_unit.sv =====
// channel  dir  handshake                signals
// s        in   s_tvalid / s_tready      s_tdata, s_tuser (drain)
// m        out  m_tvalid / m_tready      m_tdata, m_tlast (last voxel)
// cfg      in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// an item that yields no result only writes the window; a voxel result first reads the
// centre and five neighbours from the window through the single read port, and an averaged
// voxel then also goes through the bit-serial divide
// a four-entry queue lets the front keep accepting while the back works
// reset clears pointers, position and sizes (128 each); the window needs no clearing
// m_tvalid holds its transfer until m_tready; the back stalls only on a full output
module grid_velocity_extrapolation_pass_unit
    import gvx_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // velocity_in[23:0], marked_in[24], zeros
    input  logic                 s_tuser,   // drain
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // velocity_out[23:0], marked_out[24], zeros
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data
);

    localparam int XW = $clog2(MAX_X + 1);
    localparam int YW = $clog2(MAX_Y + 1);
    localparam int PW = $clog2(MAX_X * MAX_Y + 1);
    localparam int XRST = (MAX_X < 128) ? MAX_X : 128;
    localparam int YRST = (MAX_Y < 128) ? MAX_Y : 128;

    logic [XW-1:0] xs_reg, xs_next;
    logic [YW-1:0] ys_reg, ys_next;
    logic [ZW-1:0] zs_reg, zs_next;
    logic [PW-1:0] plane;
    logic          cfg_acc;
    logic          restart;
    logic          push;
    cmd_t          push_cmd;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    cmd_t          q_cmd;
    entry_t        out_entry;
    entry_t        in_entry;

    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_acc   = cfg_valid;
        restart   = 1'b0;
        xs_next   = xs_reg;
        ys_next   = ys_reg;
        zs_next   = zs_reg;
        if (cfg_acc)
        begin
            case (cfg_index)
                REG_X_SIZE:
                begin
                    restart = 1'b1;
                    if (cfg_data[7:0] == '0)
                        xs_next = XW'(1);
                    else if (32'(cfg_data[7:0]) > MAX_X)
                        xs_next = XW'(MAX_X);
                    else
                        xs_next = XW'(cfg_data[7:0]);
                end
                REG_Y_SIZE:
                begin
                    restart = 1'b1;
                    if (cfg_data[7:0] == '0)
                        ys_next = YW'(1);
                    else if (32'(cfg_data[7:0]) > MAX_Y)
                        ys_next = YW'(MAX_Y);
                    else
                        ys_next = YW'(cfg_data[7:0]);
                end
                REG_Z_SIZE:
                begin
                    restart = 1'b1;
                    if (cfg_data == '0)
                        zs_next = ZW'(1);
                    else if (32'(cfg_data) > MAX_Z)
                        zs_next = ZW'(MAX_Z);
                    else
                        zs_next = ZW'(cfg_data);
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        plane          = PW'(xs_reg) * PW'(ys_reg);
        in_entry.vel   = s_tdata[VEL_W-1:0];
        in_entry.mark  = s_tdata[VEL_W];
        m_tdata        = {7'd0, out_entry.mark, out_entry.vel};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xs_reg <= XW'(XRST);
            ys_reg <= YW'(YRST);
            zs_reg <= ZW'(128);
        end
        else
        begin
            xs_reg <= xs_next;
            ys_reg <= ys_next;
            zs_reg <= zs_next;
        end
    end

    gvx_front #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .xs       (xs_reg),
        .ys       (ys_reg),
        .zs       (zs_reg),
        .plane    (plane),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_entry (in_entry),
        .in_drain (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    gvx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_cmd   (q_cmd)
    );

    gvx_back #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .xs        (xs_reg),
        .plane     (plane),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (out_entry),
        .out_last  (m_tlast)
    );

endmodule

// ===== src/gvx_front.sv =====
module gvx_front
    import gvx_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   restart,
    input  logic [$clog2(MAX_X+1)-1:0]             xs,
    input  logic [$clog2(MAX_Y+1)-1:0]             ys,
    input  logic [ZW-1:0]                          zs,
    input  logic [$clog2(MAX_X*MAX_Y+1)-1:0]       plane,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  entry_t                                 in_entry,
    input  logic                                   in_drain,
    output logic                                   push,
    output cmd_t                                   push_cmd,
    input  logic                                   q_full
);

    localparam int XW = $clog2(MAX_X + 1);
    localparam int YW = $clog2(MAX_Y + 1);
    localparam int CW = $clog2(MAX_X);
    localparam int RW = $clog2(MAX_Y);
    localparam int PW = $clog2(MAX_X * MAX_Y + 1);

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [ZPW-1:0] pln_reg, pln_next;
    logic [PW-1:0]  fill_reg, fill_next;
    logic           acc;
    logic           drop;
    logic           col_end;
    logic           row_end;

    always_comb
    begin
        in_ready = !q_full;
        acc      = in_valid && !q_full;
        drop     = in_drain && (fill_reg == '0);
        push     = acc && !drop;
        col_end  = (XW'(col_reg) + XW'(1)) >= xs;
        row_end  = (YW'(row_reg) + YW'(1)) >= ys;

        push_cmd.entry             = in_drain ? '0 : in_entry;
        push_cmd.emit              = (fill_reg == plane);
        push_cmd.nb_en[NB_XP]      = !col_end;
        push_cmd.nb_en[NB_XM]      = (col_reg != '0);
        push_cmd.nb_en[NB_YP]      = !row_end;
        push_cmd.nb_en[NB_YM]      = (row_reg != '0);
        push_cmd.nb_en[NB_ZP]      = (ZW'(pln_reg) + ZW'(1)) < zs;
        push_cmd.nb_en[NB_ZM]      = (pln_reg != '0);
        push_cmd.last              = col_end && row_end && !push_cmd.nb_en[NB_ZP];

        col_next  = col_reg;
        row_next  = row_reg;
        pln_next  = pln_reg;
        fill_next = fill_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            pln_next  = '0;
            fill_next = '0;
        end
        else if (push)
        begin
            if (!push_cmd.emit)
            begin
                fill_next = fill_reg + PW'(1);
            end
            else if (push_cmd.last)
            begin
                col_next  = '0;
                row_next  = '0;
                pln_next  = '0;
                fill_next = '0;
            end
            else if (!col_end)
            begin
                col_next = col_reg + CW'(1);
            end
            else
            begin
                col_next = '0;
                if (!row_end)
                begin
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    row_next = '0;
                    pln_next = pln_reg + ZPW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pln_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pln_reg  <= pln_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== src/gvx_queue.sv =====
module gvx_queue
    import gvx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic pop_valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    localparam int QAW = $clog2(QDEPTH);

    cmd_t             slot_reg [QDEPTH];
    logic [QAW-1:0]   wp_reg, wp_next;
    logic [QAW-1:0]   rp_reg, rp_next;
    logic [QAW:0]     cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        full      = (cnt_reg == (QAW+1)'(QDEPTH));
        pop_valid = (cnt_reg != '0);
        pop_cmd   = slot_reg[rp_reg];
        do_push   = push && !full;
        do_pop    = pop && pop_valid;
        wp_next   = do_push ? wp_reg + QAW'(1) : wp_reg;
        rp_next   = do_pop ? rp_reg + QAW'(1) : rp_reg;
        cnt_next  = cnt_reg + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/gvx_back.sv =====
module gvx_back
    import gvx_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(MAX_X+1)-1:0]        xs,
    input  logic [$clog2(MAX_X*MAX_Y+1)-1:0]  plane,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  cmd_t                              q_cmd,
    output logic                              out_valid,
    input  logic                              out_ready,
    output entry_t                            out_entry,
    output logic                              out_last
);

    localparam int PW    = $clog2(MAX_X * MAX_Y + 1);
    localparam int KW    = PW + 1;
    localparam int DEPTH = 2 * MAX_X * MAX_Y + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int DCW   = $clog2(SUM_W + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_FIN  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } back_state_t;

    entry_t                   mem [DEPTH];
    entry_t                   rdata_reg;
    back_state_t              state_reg, state_next;
    logic [AW-1:0]            wp_reg, wp_next;
    logic [AW-1:0]            base_reg, base_next;
    logic [2:0]               idx_reg, idx_next;
    cmd_t                     cmd_reg, cmd_next;
    entry_t                   ctr_reg, ctr_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [SUM_W-1:0]         dvd_reg, dvd_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [DCW-1:0]           dcnt_reg, dcnt_next;
    logic                     neg_reg, neg_next;
    entry_t                   res_reg, res_next;
    logic                     ov_reg, ov_next;
    entry_t                   od_reg, od_next;
    logic                     ol_reg, ol_next;
    logic                     mem_we;
    logic [KW-1:0]            kval;
    logic [AW:0]              diff;
    logic [AW-1:0]            rd_addr;
    logic [CNT_W:0]           r2;
    logic                     ge;
    logic [SUM_W-1:0]         quo;
    logic                     out_free;

    always_comb
    begin
        // distance back from the newest entry for each read slot
        case (idx_reg)
            3'd0:    kval = KW'(plane);
            3'd1:    kval = KW'(plane) - KW'(1);
            3'd2:    kval = KW'(plane) + KW'(1);
            3'd3:    kval = KW'(plane) - KW'(xs);
            3'd4:    kval = KW'(plane) + KW'(xs);
            default: kval = {plane, 1'b0};
        endcase
        diff = {1'b0, base_reg} - {1'b0, AW'(kval)};
        if (diff[AW])
        begin
            diff = diff + (AW+1)'(DEPTH);
        end
        rd_addr = diff[AW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        ctr_next   = ctr_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        out_free   = !ov_reg || out_ready;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        ol_next    = ol_reg;
        r2         = {rem_reg, dvd_reg[SUM_W-1]};
        ge         = r2 >= {1'b0, cnt_reg};
        quo        = '0;

        case (state_reg)
            S_IDLE:
            begin
                q_pop = 1'b1;
                if (q_valid)
                begin
                    mem_we    = 1'b1;
                    base_next = wp_reg;
                    wp_next   = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                    cmd_next  = q_cmd;
                    idx_next  = '0;
                    // the newest entry is the neighbour one plane ahead
                    if (q_cmd.nb_en[NB_ZP] && q_cmd.entry.mark)
                    begin
                        sum_next = {{(SUM_W-VEL_W){q_cmd.entry.vel[VEL_W-1]}},
                                    q_cmd.entry.vel};
                        cnt_next = CNT_W'(1);
                    end
                    else
                    begin
                        sum_next = '0;
                        cnt_next = '0;
                    end
                    if (q_cmd.emit)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd1)
                begin
                    ctr_next = rdata_reg;
                end
                else if (idx_reg != 3'd0)
                begin
                    if (cmd_reg.nb_en[idx_reg - 3'd2] && rdata_reg.mark)
                    begin
                        sum_next = sum_reg + {{(SUM_W-VEL_W){rdata_reg.vel[VEL_W-1]}},
                                              rdata_reg.vel};
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                if (idx_reg == 3'd6)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (ctr_reg.mark || cnt_reg == '0)
                begin
                    res_next   = ctr_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    neg_next   = sum_reg[SUM_W-1];
                    dvd_next   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next  = ge ? CNT_W'(r2 - {1'b0, cnt_reg}) : r2[CNT_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], ge};
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(SUM_W - 1))
                begin
                    quo           = neg_reg ? -dvd_next : dvd_next;
                    res_next.vel  = quo[VEL_W-1:0];
                    res_next.mark = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = res_reg;
                    ol_next    = cmd_reg.last;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid = ov_reg;
        out_entry = od_reg;
        out_last  = ol_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= q_cmd.entry;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        ctr_reg  <= ctr_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== tb/sv/tb_grid_velocity_extrapolation_pass_unit.sv =====
module tb_grid_velocity_extrapolation_pass_unit;
    import gvx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH = 2 * DEF_MAX_X * DEF_MAX_Y + 1;
    localparam int RAND_ITEMS = 950;
    localparam int SETTLE = 100;

    typedef struct {
        logic signed [VEL_W-1:0] vel;
        bit                      mark;
        bit                      last;
    } voxel_t;

    typedef struct {
        bit                      is_cfg;
        logic [CFG_IDX_W-1:0]    idx;
        int                      val;
        logic signed [VEL_W-1:0] vel;
        bit                      mark;
        bit                      drain;
        bit                      chk;
        logic signed [VEL_W-1:0] ev;
        bit                      em;
        bit                      el;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // velocity_in[23:0], marked_in[24], zeros
    logic                 s_tuser;   // drain
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // velocity_out[23:0], marked_out[24], zeros
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DW-1:0]    cfg_data;

    grid_velocity_extrapolation_pass_unit dut (.*);

    // extrapolation predictor state
    logic [VEL_W:0] win [WIN_DEPTH];
    int wr_ptr;
    int col, row, pln, fill;
    int x_reg, y_reg, z_reg;

    voxel_t pending_voxels[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;

    plan_row_t plan [] = '{
        '{1, REG_X_SIZE, 1, 0, 0, 0, 0, 0, 0, 0},
        '{1, REG_Y_SIZE, 1, 0, 0, 0, 0, 0, 0, 0},
        '{1, REG_Z_SIZE, 3, 0, 0, 0, 0, 0, 0, 0},
        // drain on an empty window is ignored
        '{0, 0, 0, 24'sd0, 0, 1, 0, 0, 0, 0},
        '{0, 0, 0, 24'sd8388607, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 24'sd5, 0, 0, 1, 24'sd8388607, 1, 0},
        '{0, 0, 0, -24'sd3, 0, 0, 1, 24'sd8388607, 1, 0},
        // no marked neighbour: passes through unmarked
        '{0, 0, 0, 24'sd0, 0, 1, 1, -24'sd3, 0, 1},
        '{1, REG_X_SIZE, 3, 0, 0, 0, 0, 0, 0, 0},
        '{1, REG_Z_SIZE, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, -24'sd8388608, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 24'sd7, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, -24'sd1, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 24'sd0, 0, 1, 1, -24'sd8388608, 1, 0},
        // negative average truncates toward zero
        '{0, 0, 0, 24'sd0, 0, 1, 1, -24'sd4194304, 1, 0},
        '{0, 0, 0, 24'sd0, 0, 1, 1, -24'sd1, 1, 1},
        // zero size acts as one
        '{1, REG_X_SIZE, 1, 0, 0, 0, 0, 0, 0, 0},
        '{1, REG_Z_SIZE, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 24'sd9, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 24'sd0, 0, 1, 1, 24'sd9, 0, 1}
    };

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int clamp_size(int v, int max_v);
        if (v == 0)
            return 1;
        if (v > max_v)
            return max_v;
        return v;
    endfunction

    function automatic logic [VEL_W:0] win_back(int k);
        return win[(wr_ptr + WIN_DEPTH - 1 - (k % WIN_DEPTH)) % WIN_DEPTH];
    endfunction

    function automatic void restart_pass();
        col = 0;
        row = 0;
        pln = 0;
        fill = 0;
    endfunction

    function automatic void set_size(logic [CFG_IDX_W-1:0] idx, int val);
        if (idx == REG_X_SIZE)
            x_reg = val & 8'hff;
        else if (idx == REG_Y_SIZE)
            y_reg = val & 8'hff;
        else if (idx == REG_Z_SIZE)
            z_reg = val & 11'h7ff;
        restart_pass();
    endfunction

    function automatic bit extrapolate(logic signed [VEL_W-1:0] v, bit mk, bit dr,
                                       output voxel_t res);
        int xs, ys, zs, plane, cnt;
        longint sum;
        logic [VEL_W:0] c, nb;
        bit [NB_N-1:0] en;
        int offs [NB_N];
        xs = clamp_size(x_reg, DEF_MAX_X);
        ys = clamp_size(y_reg, DEF_MAX_Y);
        zs = clamp_size(z_reg, MAX_Z);
        plane = xs * ys;
        sum = 0;
        cnt = 0;
        res = '{0, 0, 0};
        if (dr && fill == 0)
            return 0;
        win[wr_ptr] = dr ? '0 : {mk, v};
        wr_ptr = (wr_ptr + 1) % WIN_DEPTH;
        if (fill < plane)
        begin
            fill++;
            return 0;
        end
        c = win_back(plane);
        res.vel = c[VEL_W-1:0];
        res.mark = c[VEL_W];
        if (!res.mark)
        begin
            en[NB_XP] = col + 1 < xs;
            en[NB_XM] = col > 0;
            en[NB_YP] = row + 1 < ys;
            en[NB_YM] = row > 0;
            en[NB_ZP] = pln + 1 < zs;
            en[NB_ZM] = pln > 0;
            offs[NB_XP] = plane - 1;
            offs[NB_XM] = plane + 1;
            offs[NB_YP] = plane - xs;
            offs[NB_YM] = plane + xs;
            offs[NB_ZP] = 0;
            offs[NB_ZM] = 2 * plane;
            for (int i = 0; i < NB_N; i++)
            begin
                if (en[i])
                begin
                    nb = win_back(offs[i]);
                    if (nb[VEL_W])
                    begin
                        sum += longint'($signed(nb[VEL_W-1:0]));
                        cnt++;
                    end
                end
            end
            if (cnt > 0)
            begin
                res.vel = VEL_W'(sum / cnt);
                res.mark = 1;
            end
        end
        res.last = col == xs - 1 && row == ys - 1 && pln == zs - 1;
        if (res.last)
            restart_pass();
        else
        begin
            col++;
            if (col >= xs)
            begin
                col = 0;
                row++;
                if (row >= ys)
                begin
                    row = 0;
                    pln++;
                end
            end
        end
        return 1;
    endfunction

    task automatic wait_results_done();
        while (pending_voxels.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, int val);
        wait_results_done();
        // items that yield nothing may still sit in the front queue
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DW-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        set_size(idx, val);
    endtask

    task automatic send_voxel(logic signed [VEL_W-1:0] v, bit mk, bit dr, bit chk,
                              voxel_t typed);
        voxel_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, mk, v};
        s_tuser <= dr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (extrapolate(v, mk, dr, res))
            pending_voxels.push_back(chk ? typed : res);
    endtask

    function automatic logic signed [VEL_W-1:0] rand_vel();
        case ($urandom_range(9))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return $urandom_range(1) ? -24'sd1 : 24'sd0;
            default: return VEL_W'($urandom);
        endcase
    endfunction

    // receive side: stall and check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_voxels.size() == 0)
                begin
                    $error("unexpected voxel transfer: data %h last %b", m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    voxel_t e;
                    e = pending_voxels.pop_front();
                    if (m_tdata[VEL_W-1:0] !== e.vel)
                    begin
                        $error("velocity_out expected %0d actual %0d", e.vel,
                               $signed(m_tdata[VEL_W-1:0]));
                        errors++;
                    end
                    if (m_tdata[VEL_W] !== e.mark)
                    begin
                        $error("marked_out expected %0b actual %0b", e.mark, m_tdata[VEL_W]);
                        errors++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last_voxel expected %0b actual %0b", e.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    initial
    begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int sent, phase, xs, ys, zs, n_vox, plane, n_items;
        int sizes [4][3];
        int idle_modes [4][2];
        voxel_t none;
        sizes = '{'{255, 1, 2}, '{0, 255, 1}, '{2, 2, 2047}, '{128, 2, 1}};
        idle_modes = '{'{0, 0}, '{53, 0}, '{0, 53}, '{23, 23}};
        none = '{0, 0, 0};
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_SIZE;
        cfg_data = '0;
        wr_ptr = 0;
        x_reg = 128;
        y_reg = 128;
        z_reg = 128;
        restart_pass();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                s_tvalid <= 1'b0;
                write_size(plan[i].idx, plan[i].val);
            end
            else
                send_voxel(plan[i].vel, plan[i].mark, plan[i].drain, plan[i].chk,
                           '{plan[i].ev, plan[i].em, plan[i].el});
        end

        sent = 0;
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            s_tvalid <= 1'b0;
            if (phase < 4)
            begin
                xs = sizes[phase][0];
                ys = sizes[phase][1];
                zs = sizes[phase][2];
            end
            else
            begin
                xs = $urandom_range(6, 1);
                ys = $urandom_range(6, 1);
                zs = $urandom_range(5, 1);
            end
            write_size(REG_X_SIZE, xs);
            write_size(REG_Y_SIZE, ys);
            write_size(REG_Z_SIZE, zs);
            send_idle_pct = idle_modes[phase % 4][0];
            recv_stall_pct = idle_modes[phase % 4][1];
            plane = clamp_size(xs, DEF_MAX_X) * clamp_size(ys, DEF_MAX_Y);
            n_vox = plane * clamp_size(zs, MAX_Z);
            n_items = (n_vox + plane <= 400) ? n_vox + plane : 150;
            for (int i = 0; i < n_items; i++)
            begin
                // hold off once until the output side has caught up
                if (phase == 1 && i == (3 * n_items) / 4)
                begin
                    s_tvalid <= 1'b0;
                    wait_results_done();
                    @(posedge clk);
                end
                if (i < n_vox)
                    send_voxel(rand_vel(), $urandom_range(99) < 40,
                               $urandom_range(99) < 4, 0, none);
                else if ($urandom_range(9) == 0)
                    send_voxel(rand_vel(), $urandom_range(1), 0, 0, none);
                else
                    send_voxel(rand_vel(), $urandom_range(1), 1, 0, none);
                sent++;
            end
            // stray drains follow; after a closed grid they are ignored
            repeat ($urandom_range(2)) send_voxel(0, 0, 1, 0, none);
            phase++;
        end
        s_tvalid <= 1'b0;
        wait_results_done();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/gvx_pkg.sv
src/gvx_front.sv
src/gvx_queue.sv
src/gvx_back.sv
src/grid_velocity_extrapolation_pass_unit.sv
tb/sv/tb_grid_velocity_extrapolation_pass_unit.sv
